FILE: src/bhtp_pkg.sv
package bhtp_pkg;

	localparam int KEY_W = 64;
	localparam int VALUE_W = 32;
	localparam int SLOT_IDX_W = 10;

	localparam int DEF_HASH_BUCKETS = 256;
	localparam int DEF_BUCKET_WAYS = 4;
	localparam int DEF_TABLE_SLOTS = 1024;

	localparam int MOD_BITS = 8;
	localparam int MOD_CYCLES = KEY_W / MOD_BITS;
	localparam int MOD_CNT_W = $clog2(MOD_CYCLES);

	localparam logic MODE_LOOKUP = 1'b0;
	localparam logic MODE_INSERT = 1'b1;

	localparam logic STATUS_OK = 1'b0;
	localparam logic STATUS_FAIL = 1'b1;

	typedef struct packed {
		logic               valid;
		logic [KEY_W-1:0]   key;
		logic [VALUE_W-1:0] value;
	} entry_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HASH,
		ST_START,
		ST_READ,
		ST_CHECK,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic mod_step;
		logic start_probe;
		logic clr_step;
		logic mem_rd;
		logic advance;
		logic ins_wr;
		logic res_set;
		logic res_fail;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic mod_last;
		logic start_oob;
		logic slot_last;
		logic rd_valid;
		logic key_match;
		logic is_insert;
		logic out_free;
	} sts_t;

endpackage

FILE: src/bhtp_req_if.sv
interface bhtp_req_if;
	logic                          valid;
	logic                          ready;
	logic                          mode;
	logic [bhtp_pkg::KEY_W-1:0]    key;
	logic [bhtp_pkg::VALUE_W-1:0]  value_handle;

	modport source(output valid, output mode, output key, output value_handle, input ready);
	modport sink(input valid, input mode, input key, input value_handle, output ready);
endinterface

FILE: src/bhtp_rsp_if.sv
interface bhtp_rsp_if;
	logic                            valid;
	logic                            ready;
	logic                            status;
	logic [bhtp_pkg::SLOT_IDX_W-1:0] slot_index;
	logic [bhtp_pkg::VALUE_W-1:0]    found_value;

	modport source(output valid, output status, output slot_index, output found_value,
		input ready);
	modport sink(input valid, input status, input slot_index, input found_value,
		output ready);
endinterface

FILE: src/bhtp_ctrl.sv
module bhtp_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  bhtp_pkg::sts_t   sts,
	output bhtp_pkg::cmd_t   cmd
);

	bhtp_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bhtp_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bhtp_pkg::ST_CLEAR: begin
				if (sts.clr_last) begin
					state_d = bhtp_pkg::ST_IDLE;
				end
			end
			bhtp_pkg::ST_IDLE: begin
				if (req_valid) begin
					state_d = bhtp_pkg::ST_HASH;
				end
			end
			bhtp_pkg::ST_HASH: begin
				if (sts.mod_last) begin
					state_d = bhtp_pkg::ST_START;
				end
			end
			bhtp_pkg::ST_START: begin
				state_d = sts.start_oob ? bhtp_pkg::ST_DONE : bhtp_pkg::ST_READ;
			end
			bhtp_pkg::ST_READ: begin
				state_d = bhtp_pkg::ST_CHECK;
			end
			bhtp_pkg::ST_CHECK: begin
				if (!sts.rd_valid || (!sts.is_insert && sts.key_match) || sts.slot_last) begin
					state_d = bhtp_pkg::ST_DONE;
				end else begin
					state_d = bhtp_pkg::ST_READ;
				end
			end
			bhtp_pkg::ST_DONE: begin
				if (sts.out_free) begin
					state_d = bhtp_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bhtp_pkg::ST_CLEAR;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		req_ready = 1'b0;
		unique case (state_q)
			bhtp_pkg::ST_CLEAR: begin
				cmd.clr_step = 1'b1;
			end
			bhtp_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				cmd.load = req_valid;
			end
			bhtp_pkg::ST_HASH: begin
				cmd.mod_step = 1'b1;
			end
			bhtp_pkg::ST_START: begin
				if (sts.start_oob) begin
					cmd.res_set = 1'b1;
					cmd.res_fail = 1'b1;
				end else begin
					cmd.start_probe = 1'b1;
				end
			end
			bhtp_pkg::ST_READ: begin
				cmd.mem_rd = 1'b1;
			end
			bhtp_pkg::ST_CHECK: begin
				if (!sts.rd_valid) begin
					cmd.res_set = 1'b1;
					cmd.res_fail = !sts.is_insert;
					cmd.ins_wr = sts.is_insert;
				end else if (!sts.is_insert && sts.key_match) begin
					cmd.res_set = 1'b1;
				end else if (sts.slot_last) begin
					cmd.res_set = 1'b1;
					cmd.res_fail = 1'b1;
				end else begin
					cmd.advance = 1'b1;
				end
			end
			bhtp_pkg::ST_DONE: begin
				cmd.out_load = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

FILE: src/bhtp_dp.sv
module bhtp_dp #(
	parameter int HASH_BUCKETS = bhtp_pkg::DEF_HASH_BUCKETS,
	parameter int BUCKET_WAYS  = bhtp_pkg::DEF_BUCKET_WAYS,
	parameter int TABLE_SLOTS  = bhtp_pkg::DEF_TABLE_SLOTS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  bhtp_pkg::cmd_t                    cmd,
	output bhtp_pkg::sts_t                    sts,
	input  logic                              req_mode,
	input  logic [bhtp_pkg::KEY_W-1:0]        req_key,
	input  logic [bhtp_pkg::VALUE_W-1:0]      req_value_handle,
	output logic                              rsp_valid,
	input  logic                              rsp_ready,
	output logic                              rsp_status,
	output logic [bhtp_pkg::SLOT_IDX_W-1:0]   rsp_slot_index,
	output logic [bhtp_pkg::VALUE_W-1:0]      rsp_found_value
);

	localparam int AW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam int RW = (HASH_BUCKETS > 1) ? $clog2(HASH_BUCKETS) : 1;
	localparam int WW = $clog2(BUCKET_WAYS + 1);
	localparam int STW = RW + WW;
	localparam int IW = bhtp_pkg::SLOT_IDX_W;

	bhtp_pkg::entry_t mem [TABLE_SLOTS];
	bhtp_pkg::entry_t rd_q;

	logic                               mode_q;
	logic [bhtp_pkg::KEY_W-1:0]         key_q;
	logic [bhtp_pkg::KEY_W-1:0]         shift_q;
	logic [bhtp_pkg::VALUE_W-1:0]       handle_q;
	logic [RW-1:0]                      rem_q;
	logic [bhtp_pkg::MOD_CNT_W-1:0]     mod_cnt_q;
	logic [AW-1:0]                      slot_q;
	logic [AW-1:0]                      clr_q;

	logic                               res_status_q;
	logic [IW-1:0]                      res_slot_q;
	logic [bhtp_pkg::VALUE_W-1:0]       res_value_q;

	logic                               out_valid_q;
	logic                               out_status_q;
	logic [IW-1:0]                      out_slot_q;
	logic [bhtp_pkg::VALUE_W-1:0]       out_value_q;

	logic [RW:0]                        rem_next;
	logic [STW-1:0]                     start;
	logic [31:0]                        start_ext;
	logic [AW+IW-1:0]                   slot_ext;
	logic [AW-1:0]                      mem_addr;
	bhtp_pkg::entry_t                   wr_entry;

	// restoring remainder, one key byte per cycle, msb first
	always_comb begin
		logic [RW:0] t;
		t = {1'b0, rem_q};
		for (int i = 0; i < bhtp_pkg::MOD_BITS; i++) begin
			t = {t[RW-1:0], shift_q[bhtp_pkg::KEY_W-1-i]};
			if (t >= (RW+1)'(HASH_BUCKETS)) begin
				t = t - (RW+1)'(HASH_BUCKETS);
			end
		end
		rem_next = t;
	end

	assign start = STW'(rem_q) * STW'(BUCKET_WAYS);
	assign start_ext = 32'(start);
	assign slot_ext = {{IW{1'b0}}, slot_q};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= req_mode;
			key_q <= req_key;
			shift_q <= req_key;
			handle_q <= req_value_handle;
			rem_q <= '0;
			mod_cnt_q <= '0;
		end else if (cmd.mod_step) begin
			shift_q <= shift_q << bhtp_pkg::MOD_BITS;
			rem_q <= rem_next[RW-1:0];
			mod_cnt_q <= mod_cnt_q + 1'b1;
		end
		if (cmd.start_probe) begin
			slot_q <= start_ext[AW-1:0];
		end else if (cmd.advance) begin
			slot_q <= slot_q + 1'b1;
		end
		if (cmd.res_set) begin
			res_status_q <= cmd.res_fail ? bhtp_pkg::STATUS_FAIL : bhtp_pkg::STATUS_OK;
			res_slot_q <= cmd.res_fail ? '0 : slot_ext[IW-1:0];
			if (cmd.res_fail) begin
				res_value_q <= '0;
			end else if (mode_q == bhtp_pkg::MODE_INSERT) begin
				res_value_q <= handle_q;
			end else begin
				res_value_q <= rd_q.value;
			end
		end
		if (cmd.out_load) begin
			out_status_q <= res_status_q;
			out_slot_q <= res_slot_q;
			out_value_q <= res_value_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_step) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// single port table
	assign mem_addr = cmd.clr_step ? clr_q : slot_q;

	always_comb begin
		wr_entry = '0;
		if (cmd.ins_wr) begin
			wr_entry.valid = 1'b1;
			wr_entry.key = key_q;
			wr_entry.value = handle_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_step || cmd.ins_wr) begin
			mem[mem_addr] <= wr_entry;
		end
		if (cmd.mem_rd) begin
			rd_q <= mem[mem_addr];
		end
	end

	assign sts.clr_last = (clr_q == AW'(TABLE_SLOTS - 1));
	assign sts.mod_last = (mod_cnt_q == bhtp_pkg::MOD_CNT_W'(bhtp_pkg::MOD_CYCLES - 1));
	assign sts.start_oob = (start_ext >= 32'(TABLE_SLOTS));
	assign sts.slot_last = (slot_q == AW'(TABLE_SLOTS - 1));
	assign sts.rd_valid = rd_q.valid;
	assign sts.key_match = (rd_q.key == key_q);
	assign sts.is_insert = (mode_q == bhtp_pkg::MODE_INSERT);
	assign sts.out_free = !out_valid_q || rsp_ready;

	assign rsp_valid = out_valid_q;
	assign rsp_status = out_status_q;
	assign rsp_slot_index = out_slot_q;
	assign rsp_found_value = out_value_q;

endmodule

FILE: src/bucketed_hash_table_probe.sv
// an accepted item is hashed, then slots are probed in turn until a result is set
// one item at a time; each probe reads the single-port table and then checks the entry,
// and the key hash runs at one key byte per cycle
// the next item is taken while a finished result waits in the output register
// reset: asynchronous, then a clearing pass over all TABLE_SLOTS slots before any item
module bucketed_hash_table_probe #(
	parameter int HASH_BUCKETS = bhtp_pkg::DEF_HASH_BUCKETS,
	parameter int BUCKET_WAYS  = bhtp_pkg::DEF_BUCKET_WAYS,
	parameter int TABLE_SLOTS  = bhtp_pkg::DEF_TABLE_SLOTS
) (
	input  logic              clk,
	input  logic              arst_n,
	bhtp_req_if.sink          req,
	bhtp_rsp_if.source        rsp
);

	bhtp_pkg::cmd_t cmd;
	bhtp_pkg::sts_t sts;

	bhtp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	bhtp_dp #(
		.HASH_BUCKETS (HASH_BUCKETS),
		.BUCKET_WAYS  (BUCKET_WAYS),
		.TABLE_SLOTS  (TABLE_SLOTS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.req_mode         (req.mode),
		.req_key          (req.key),
		.req_value_handle (req.value_handle),
		.rsp_valid        (rsp.valid),
		.rsp_ready        (rsp.ready),
		.rsp_status       (rsp.status),
		.rsp_slot_index   (rsp.slot_index),
		.rsp_found_value  (rsp.found_value)
	);

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

	localparam int NBUCKETS = bhtp_pkg::DEF_HASH_BUCKETS;
	localparam int NWAYS = bhtp_pkg::DEF_BUCKET_WAYS;
	localparam int NSLOTS = bhtp_pkg::DEF_TABLE_SLOTS;
	localparam int RANDOM_ITEMS = 1930;
	localparam int HOLD_AT = 150;
	localparam int HOLD_CYCLES = 600;
	localparam int DRAIN_CYCLES = 40;
	localparam int WATCHDOG_LIMIT = 10000;
	localparam int PRINT_LIMIT = 100;

	typedef struct packed {
		logic                         mode;
		logic [bhtp_pkg::KEY_W-1:0]   key;
		logic [bhtp_pkg::VALUE_W-1:0] value_handle;
	} probe_req_t;

	typedef struct packed {
		logic                            status;
		logic [bhtp_pkg::SLOT_IDX_W-1:0] slot_index;
		logic [bhtp_pkg::VALUE_W-1:0]    found_value;
	} probe_rsp_t;

	logic clk;
	logic arst_n;

	bhtp_req_if req_ch();
	bhtp_rsp_if rsp_ch();

	bucketed_hash_table_probe u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	bit                           tbl_valid [NSLOTS];
	logic [bhtp_pkg::KEY_W-1:0]   tbl_key [NSLOTS];
	logic [bhtp_pkg::VALUE_W-1:0] tbl_value [NSLOTS];

	probe_req_t                 req_pending_q[$];
	probe_rsp_t                 probe_expect_q[$];
	logic [bhtp_pkg::KEY_W-1:0] inserted_keys[$];
	int                         mismatches;
	int                         results_seen;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// linear probe from the bucket start up to the table end, no wrap
	function automatic probe_rsp_t probe_table(probe_req_t it);
		probe_rsp_t r;
		longint unsigned first;
		r = '0;
		r.status = bhtp_pkg::STATUS_FAIL;
		first = (64'(it.key) % 64'(NBUCKETS)) * 64'(NWAYS);
		for (longint unsigned s = first; s < NSLOTS; s++) begin
			if (!tbl_valid[s]) begin
				if (it.mode == bhtp_pkg::MODE_INSERT) begin
					tbl_valid[s] = 1'b1;
					tbl_key[s] = it.key;
					tbl_value[s] = it.value_handle;
					r.status = bhtp_pkg::STATUS_OK;
					r.slot_index = s[bhtp_pkg::SLOT_IDX_W-1:0];
					r.found_value = it.value_handle;
				end
				return r;
			end
			if (it.mode == bhtp_pkg::MODE_LOOKUP && tbl_key[s] == it.key) begin
				r.status = bhtp_pkg::STATUS_OK;
				r.slot_index = s[bhtp_pkg::SLOT_IDX_W-1:0];
				r.found_value = tbl_value[s];
				return r;
			end
		end
		return r;
	endfunction

	function automatic int idle_len();
		int r;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 15);
		return $urandom_range(30, 80);
	endfunction

	function automatic logic [bhtp_pkg::KEY_W-1:0] random_key();
		logic [bhtp_pkg::KEY_W-1:0] k;
		k = {$urandom(), $urandom()};
		// crowd the last buckets so the table end is reached often
		if ($urandom_range(3) == 0)
			k[7:0] = 8'($urandom_range(8'hF0, 8'hFF));
		return k;
	endfunction

	function automatic void add_item(logic mode, logic [bhtp_pkg::KEY_W-1:0] key,
		logic [bhtp_pkg::VALUE_W-1:0] value_handle);
		probe_req_t it;
		it.mode = mode;
		it.key = key;
		it.value_handle = value_handle;
		req_pending_q.push_back(it);
		if (mode == bhtp_pkg::MODE_INSERT)
			inserted_keys.push_back(key);
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		if (mismatches < PRINT_LIMIT)
			$display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
		mismatches++;
	endtask

	// driver
	int         send_gap;
	int         send_quiet;
	probe_req_t next_req;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.mode <= bhtp_pkg::MODE_LOOKUP;
			req_ch.key <= '0;
			req_ch.value_handle <= '0;
			send_gap = 0;
			send_quiet = 0;
		end else begin
			if (req_ch.valid && req_ch.ready)
				probe_expect_q.push_back(probe_table(
					probe_req_t'({req_ch.mode, req_ch.key, req_ch.value_handle})));
			if (!req_ch.valid || req_ch.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					req_ch.valid <= 1'b0;
				end else if (req_pending_q.size() != 0) begin
					next_req = req_pending_q.pop_front();
					req_ch.valid <= 1'b1;
					req_ch.mode <= next_req.mode;
					req_ch.key <= next_req.key;
					req_ch.value_handle <= next_req.value_handle;
					if (send_quiet > 0) begin
						send_quiet--;
						send_gap = 0;
					end else begin
						send_gap = idle_len();
						if ($urandom_range(39) == 0)
							send_quiet = $urandom_range(20, 60);
					end
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	int         recv_stall;
	int         recv_quiet;
	int         hold_left;
	bit         hold_done;
	probe_rsp_t want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			recv_stall = 0;
			recv_quiet = 0;
			hold_left = 0;
			hold_done = 1'b0;
			results_seen = 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				results_seen++;
				if (probe_expect_q.size() == 0) begin
					report_mismatch("unexpected result", rsp_ch.slot_index, '0);
				end else begin
					want = probe_expect_q.pop_front();
					if (rsp_ch.status !== want.status)
						report_mismatch("status", rsp_ch.status, want.status);
					if (rsp_ch.slot_index !== want.slot_index)
						report_mismatch("slot_index", rsp_ch.slot_index, want.slot_index);
					if (rsp_ch.found_value !== want.found_value)
						report_mismatch("found_value", rsp_ch.found_value, want.found_value);
				end
			end
			// one long hold so the block backs up into its input
			if (!hold_done && results_seen == HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else if (recv_stall > 0) begin
				recv_stall--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
				if (recv_quiet > 0) begin
					recv_quiet--;
				end else begin
					recv_stall = ($urandom_range(2) == 0) ? idle_len() : 0;
					if ($urandom_range(49) == 0)
						recv_quiet = $urandom_range(30, 100);
				end
			end
		end
	end

	int idle_cycles;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles = 0;
		end else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	initial begin
		int                         pick;
		logic [bhtp_pkg::KEY_W-1:0] k;

		arst_n <= 1'b0;

		// empty table, then hits, bucket collisions and a duplicate key
		add_item(bhtp_pkg::MODE_LOOKUP, '0, 32'hFFFF_FFFF);
		add_item(bhtp_pkg::MODE_INSERT, '0, '0);
		add_item(bhtp_pkg::MODE_INSERT, '1, '1);
		add_item(bhtp_pkg::MODE_LOOKUP, '0, 32'h0000_0001);
		add_item(bhtp_pkg::MODE_LOOKUP, '1, '0);
		add_item(bhtp_pkg::MODE_INSERT, 64'h0000_0000_0000_0100, 32'hA5A5_5A5A);
		add_item(bhtp_pkg::MODE_INSERT, '0, 32'h1234_5678);
		add_item(bhtp_pkg::MODE_LOOKUP, '0, '0);
		add_item(bhtp_pkg::MODE_LOOKUP, 64'h0000_0000_0000_0100, '0);
		add_item(bhtp_pkg::MODE_LOOKUP, 64'h0000_0000_0000_0200, '0);
		// last bucket fills, then the table end is hit
		add_item(bhtp_pkg::MODE_INSERT, 64'h7FFF_0000_0000_00FF, 32'h8000_0000);
		add_item(bhtp_pkg::MODE_INSERT, 64'h8000_0000_0000_00FF, 32'h0000_0001);
		add_item(bhtp_pkg::MODE_INSERT, 64'h0123_4567_89AB_CDFF, 32'h5555_AAAA);
		add_item(bhtp_pkg::MODE_INSERT, 64'hFEDC_BA98_7654_32FF, 32'hDEAD_BEEF);
		add_item(bhtp_pkg::MODE_LOOKUP, 64'hFEDC_BA98_7654_32FF, '0);
		add_item(bhtp_pkg::MODE_LOOKUP, 64'h0123_4567_89AB_CDFF, '0);
		add_item(bhtp_pkg::MODE_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFE, 32'h7777_7777);
		add_item(bhtp_pkg::MODE_INSERT, 64'hFFFF_FFFF_FFFF_FFFE, 32'h0F0F_0F0F);
		add_item(bhtp_pkg::MODE_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFE, '0);
		add_item(bhtp_pkg::MODE_LOOKUP, 64'h8000_0000_0000_0000, '0);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			pick = $urandom_range(99);
			if (pick < 22) begin
				if (inserted_keys.size() != 0 && $urandom_range(4) == 0)
					k = inserted_keys[$urandom_range(inserted_keys.size() - 1)];
				else
					k = random_key();
				add_item(bhtp_pkg::MODE_INSERT, k, $urandom());
			end else begin
				k = random_key();
				if (inserted_keys.size() != 0 && pick < 65) begin
					k = inserted_keys[$urandom_range(inserted_keys.size() - 1)];
					// same bucket, different key
					if (pick >= 52)
						k[bhtp_pkg::KEY_W-1:32] = $urandom();
				end
				add_item(bhtp_pkg::MODE_LOOKUP, k, $urandom());
			end
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (req_pending_q.size() != 0 || req_ch.valid || probe_expect_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
